// ===== rtl/monotonic_table_bracket_search_top_assert.svh =====
// Assertion macros shared by the bracket search RTL.
// Both macros expect clk_i in the enclosing module; MTBS_ASSERT also expects rst_ni.
`ifndef MONOTONIC_TABLE_BRACKET_SEARCH_TOP_ASSERT_SVH
`define MONOTONIC_TABLE_BRACKET_SEARCH_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Checked only while out of reset
`define MTBS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included
`define MTBS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define MTBS_ASSERT(name, prop, msg)
`define MTBS_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

// ===== rtl/mtbs_pkg.sv =====
package mtbs_pkg;

  // Table geometry
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned KEY_WIDTH   = 32;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  // Search arithmetic: room for jl + inc without wrap
  localparam int unsigned PTR_W       = IDX_W + 2;

  // Configuration registers
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 2;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = QPTR_W + 1;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_LOCATE = 2'd1,
    CMD_HUNT   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_LOCATE,
    OP_HUNT,
    OP_SIZE_ERR
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TABLE_SIZE    = 2'd0,
    CFG_WINDOW_POINTS = 2'd1,
    CFG_CORR_DIST     = 2'd2
  } cfg_idx_e;

  localparam logic [CFG_W-1:0] TABLE_SIZE_RST    = CFG_W'(2);
  localparam logic [CFG_W-1:0] WINDOW_POINTS_RST = CFG_W'(2);
  localparam logic [CFG_W-1:0] CORR_DIST_RST     = CFG_W'(1);

  typedef struct packed {
    logic [1:0]                  command;
    logic signed [KEY_WIDTH-1:0] key_value;
    logic [IDX_W-1:0]            entry_index;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] window_start;
    logic             correlated;
    logic             size_error;
  } out_item_t;

  // Classified work item handed from front to back
  typedef struct packed {
    op_e                         kind;
    logic signed [KEY_WIDTH-1:0] key;
    logic [IDX_W-1:0]            index;
  } op_t;

  typedef struct packed {
    logic [CFG_W-1:0] table_size;
    logic [CFG_W-1:0] window_points;
    logic [CFG_W-1:0] corr_dist;
  } cfg_t;

endpackage

// ===== rtl/mtbs_front.sv =====
module mtbs_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mtbs_pkg::in_item_t in_item_i,
  input  mtbs_pkg::cfg_t    cfg_i,
  input  logic              q_full_i,
  output logic              push_o,
  output mtbs_pkg::op_t     op_o
);
  import mtbs_pkg::*;

  logic size_bad;

  // Size settings check, done once per item here
  assign size_bad = (cfg_i.table_size < CFG_W'(2)) ||
                    (cfg_i.window_points < CFG_W'(2)) ||
                    (cfg_i.window_points > cfg_i.table_size) ||
                    (cfg_i.table_size > CFG_W'(TABLE_DEPTH));

  assign in_stall_o = q_full_i;

  // Classify the command; the unused code is consumed and dropped
  always_comb begin
    op_o.key   = in_item_i.key_value;
    op_o.index = in_item_i.entry_index;
    op_o.kind  = OP_WRITE;
    push_o     = 1'b0;
    case (cmd_e'(in_item_i.command))
      CMD_WRITE: begin
        op_o.kind = OP_WRITE;
        push_o    = in_valid_i && !q_full_i;
      end
      CMD_LOCATE: begin
        op_o.kind = size_bad ? OP_SIZE_ERR : OP_LOCATE;
        push_o    = in_valid_i && !q_full_i;
      end
      CMD_HUNT: begin
        op_o.kind = size_bad ? OP_SIZE_ERR : OP_HUNT;
        push_o    = in_valid_i && !q_full_i;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/mtbs_queue.sv =====
`include "monotonic_table_bracket_search_top_assert.svh"

module mtbs_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mtbs_pkg::op_t item_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output mtbs_pkg::op_t item_o
);
  import mtbs_pkg::*;

  op_t                slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = slot_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  `MTBS_ASSERT_ALWAYS(a_q_count_bound, count_q <= QCNT_W'(QUEUE_DEPTH), "queue count overrun")
  `MTBS_ASSERT(a_q_no_push_full, push_i |-> !full_o, "push into full queue")
  `MTBS_ASSERT(a_q_no_pop_empty, pop_i |-> valid_o, "pop from empty queue")

endmodule

// ===== rtl/mtbs_back.sv =====
`include "monotonic_table_bracket_search_top_assert.svh"

module mtbs_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mtbs_pkg::cfg_t      cfg_i,
  input  logic                op_valid_i,
  input  mtbs_pkg::op_t       op_i,
  output logic                op_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mtbs_pkg::out_item_t out_item_o
);
  import mtbs_pkg::*;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0; // take next op, read entry 0
  localparam logic [2:0] S_K0   = 3'd1; // first key in, read last key
  localparam logic [2:0] S_KN   = 3'd2; // last key in, table sense known
  localparam logic [2:0] S_HB   = 3'd3; // key at saved bracket in
  localparam logic [2:0] S_UP   = 3'd4; // hunting upward
  localparam logic [2:0] S_DN   = 3'd5; // hunting downward
  localparam logic [2:0] S_BIS  = 3'd6; // bisection probe
  localparam logic [2:0] S_DONE = 3'd7; // emit result

  logic [2:0]                  state_q, state_d;
  logic [KEY_WIDTH-1:0]        key_table_q [TABLE_DEPTH];
  logic [KEY_WIDTH-1:0]        rd_data_q;
  logic [IDX_W-1:0]            rd_addr;
  logic                        tbl_we;

  logic signed [KEY_WIDTH-1:0] key_q, key_d;
  logic signed [KEY_WIDTH-1:0] k0_q, k0_d;
  logic                        asc_q, asc_d;
  logic                        hunt_q, hunt_d;
  logic [PTR_W-1:0]            jl_q, jl_d;
  logic [PTR_W-1:0]            ju_q, ju_d;
  logic [PTR_W-1:0]            mid_q, mid_d;
  logic [PTR_W-1:0]            inc_q, inc_d;
  logic [IDX_W-1:0]            saved_q, saved_d;

  logic                        out_valid_q, out_valid_d;
  out_item_t                   out_q, out_d;
  logic                        out_load;
  logic                        out_free;

  logic [PTR_W-1:0]            n_m1;
  logic [PTR_W-1:0]            inc2;
  logic [PTR_W-1:0]            step_up;
  logic                        ge;
  logic                        hit;
  logic                        chk;

  logic signed [PTR_W-1:0]     win_lo;
  logic signed [PTR_W-1:0]     win_hi;
  logic signed [PTR_W-1:0]     win_start;
  logic [PTR_W-1:0]            move;
  logic                        corr;

  assign out_free = !out_valid_q || !out_stall_i;
  assign n_m1     = PTR_W'(cfg_i.table_size) - PTR_W'(1);
  assign inc2     = inc_q << 1;
  assign step_up  = ju_q + inc2;

  // Key compare against the entry read last cycle
  assign ge  = (key_q >= $signed(rd_data_q));
  assign hit = (ge == asc_q);

  // Window start and correlation of the finished bracket
  always_comb begin
    win_lo = $signed(jl_q) - $signed(PTR_W'((cfg_i.window_points - CFG_W'(2)) >> 1));
    win_hi = $signed(PTR_W'(cfg_i.table_size)) - $signed(PTR_W'(cfg_i.window_points));
    win_start = win_lo;
    if (win_start > win_hi) begin
      win_start = win_hi;
    end
    if (win_start < $signed(PTR_W'(0))) begin
      win_start = '0;
    end
    move = (jl_q > PTR_W'(saved_q)) ? jl_q - PTR_W'(saved_q) : PTR_W'(saved_q) - jl_q;
    corr = (move <= PTR_W'(cfg_i.corr_dist));
  end

  // Search sequencer
  always_comb begin
    state_d  = state_q;
    key_d    = key_q;
    k0_d     = k0_q;
    asc_d    = asc_q;
    hunt_d   = hunt_q;
    jl_d     = jl_q;
    ju_d     = ju_q;
    mid_d    = mid_q;
    inc_d    = inc_q;
    saved_d  = saved_q;
    out_d    = out_q;
    out_load = 1'b0;
    op_pop_o = 1'b0;
    tbl_we   = 1'b0;
    rd_addr  = '0;
    chk      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (op_valid_i) begin
          case (op_i.kind)
            OP_WRITE: begin
              op_pop_o = 1'b1;
              tbl_we   = 1'b1;
            end
            OP_SIZE_ERR: begin
              if (out_free) begin
                op_pop_o = 1'b1;
                out_load = 1'b1;
                out_d.window_start = '0;
                out_d.correlated   = 1'b0;
                out_d.size_error   = 1'b1;
              end
            end
            OP_LOCATE, OP_HUNT: begin
              op_pop_o = 1'b1;
              key_d    = op_i.key;
              hunt_d   = (op_i.kind == OP_HUNT);
              state_d  = S_K0;
            end
            default: begin
              op_pop_o = 1'b1;
            end
          endcase
        end
      end

      S_K0: begin
        k0_d    = $signed(rd_data_q);
        rd_addr = n_m1[IDX_W-1:0];
        state_d = S_KN;
      end

      S_KN: begin
        asc_d = ($signed(rd_data_q) >= k0_q);
        if (hunt_q && (PTR_W'(saved_q) <= n_m1)) begin
          jl_d    = PTR_W'(saved_q);
          rd_addr = saved_q;
          state_d = S_HB;
        end else begin
          jl_d = '0;
          ju_d = n_m1;
          chk  = 1'b1;
        end
      end

      S_HB: begin
        inc_d = PTR_W'(1);
        if (hit) begin
          if (jl_q + PTR_W'(1) >= n_m1) begin
            ju_d = n_m1;
            chk  = 1'b1;
          end else begin
            ju_d    = jl_q + PTR_W'(1);
            rd_addr = ju_d[IDX_W-1:0];
            state_d = S_UP;
          end
        end else begin
          ju_d = jl_q;
          if (jl_q <= PTR_W'(1)) begin
            jl_d = '0;
            chk  = 1'b1;
          end else begin
            jl_d    = jl_q - PTR_W'(1);
            rd_addr = jl_d[IDX_W-1:0];
            state_d = S_DN;
          end
        end
      end

      S_UP: begin
        if (!hit) begin
          chk = 1'b1;
        end else begin
          jl_d  = ju_q;
          inc_d = inc2;
          if (step_up >= n_m1) begin
            ju_d = n_m1;
            chk  = 1'b1;
          end else begin
            ju_d    = step_up;
            rd_addr = step_up[IDX_W-1:0];
          end
        end
      end

      S_DN: begin
        if (hit) begin
          chk = 1'b1;
        end else begin
          ju_d  = jl_q;
          inc_d = inc2;
          if (inc2 >= jl_q) begin
            jl_d = '0;
            chk  = 1'b1;
          end else begin
            jl_d    = jl_q - inc2;
            rd_addr = jl_d[IDX_W-1:0];
          end
        end
      end

      S_BIS: begin
        if (hit) begin
          jl_d = mid_q;
        end else begin
          ju_d = mid_q;
        end
        chk = 1'b1;
      end

      S_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d.window_start = win_start[IDX_W-1:0];
          out_d.correlated   = corr;
          out_d.size_error   = 1'b0;
          saved_d = jl_q[IDX_W-1:0];
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Bracket still wider than one step: probe its midpoint
    if (chk) begin
      if (ju_d - jl_d > PTR_W'(1)) begin
        mid_d   = (ju_d + jl_d) >> 1;
        rd_addr = mid_d[IDX_W-1:0];
        state_d = S_BIS;
      end else begin
        state_d = S_DONE;
      end
    end
  end

  // Result register; a new result may load as the old one transfers
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      saved_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      saved_q     <= saved_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    k0_q   <= k0_d;
    asc_q  <= asc_d;
    hunt_q <= hunt_d;
    jl_q   <= jl_d;
    ju_q   <= ju_d;
    mid_q  <= mid_d;
    inc_q  <= inc_d;
    out_q  <= out_d;
  end

  // Key table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      key_table_q[op_i.index] <= op_i.key;
    end
    rd_data_q <= key_table_q[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `MTBS_ASSERT(a_bis_mid_inside, (state_q == S_BIS) |-> (mid_q > jl_q) && (mid_q < ju_q), "bisection midpoint outside bracket")
  `MTBS_ASSERT(a_up_probe_range, (state_q == S_UP) |-> (ju_q < n_m1) && (jl_q < ju_q), "upward hunt probe out of range")
  `MTBS_ASSERT(a_dn_probe_range, (state_q == S_DN) |-> (jl_q > PTR_W'(0)) && (jl_q < ju_q), "downward hunt probe out of range")

endmodule

// ===== rtl/monotonic_table_bracket_search_top.sv =====
// Channel   Direction  Handshake             Transfer carries
// in        input      in_valid_i/in_stall_o   command, key_value, entry_index
// out       output     out_valid_o/out_stall_i window_start, correlated, size_error
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A write is stored by the back end straight from idle, and so is a size error
// result. A locate reads the first and the last key, then makes its bisection
// probes and emits; a hunt adds a read at the saved bracket and the hunt
// compares: every probe is a read of the single key table port. Reset clears
// control and the saved bracket; the key table has no reset and needs no clearing pass.
// A 4-entry queue decouples intake from the search, so input stalls only
// when it is full; the result register frees as soon as its transfer happens.
module monotonic_table_bracket_search_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mtbs_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mtbs_pkg::out_item_t           out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mtbs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mtbs_pkg::CFG_W-1:0]     cfg_data_i
);
  import mtbs_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic push;
  logic q_full;
  op_t  push_op;
  logic q_valid;
  logic q_pop;
  op_t  q_head;

  // Configuration registers; unknown indexes are ignored
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TABLE_SIZE:    cfg_d.table_size    = cfg_data_i;
        CFG_WINDOW_POINTS: cfg_d.window_points = cfg_data_i;
        CFG_CORR_DIST:     cfg_d.corr_dist     = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.table_size    <= TABLE_SIZE_RST;
      cfg_q.window_points <= WINDOW_POINTS_RST;
      cfg_q.corr_dist     <= CORR_DIST_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  mtbs_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .cfg_i      (cfg_q),
    .q_full_i   (q_full),
    .push_o     (push),
    .op_o       (push_op)
  );

  mtbs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_op),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_head)
  );

  mtbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .op_valid_i  (q_valid),
    .op_i        (q_head),
    .op_pop_o    (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== bench/tb_monotonic_table_bracket_search_top.sv =====
module tb_monotonic_table_bracket_search_top;
  import mtbs_pkg::*;

  localparam logic signed [KEY_WIDTH-1:0] KEY_MIN = {1'b1, {(KEY_WIDTH-1){1'b0}}};
  localparam logic signed [KEY_WIDTH-1:0] KEY_MAX = {1'b0, {(KEY_WIDTH-1){1'b1}}};
  // back end may still be busy with writes after the last search result
  localparam int SETTLE_CYCLES = 32;
  localparam int RANDOM_ITEMS  = 700;

  typedef enum int {
    SHAPE_RISING,
    SHAPE_FALLING,
    SHAPE_FLAT,
    SHAPE_SCRAMBLED
  } table_shape_e;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  in_item_t               in_item_i   = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  out_item_t              out_item_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_W-1:0]       cfg_data_i  = '0;

  // Shadow state of the search engine
  logic signed [KEY_WIDTH-1:0] key_store [TABLE_DEPTH];
  logic [IDX_W-1:0]            last_bracket = '0;
  logic [CFG_W-1:0]            cfg_size     = TABLE_SIZE_RST;
  logic [CFG_W-1:0]            cfg_window   = WINDOW_POINTS_RST;
  logic [CFG_W-1:0]            cfg_reach    = CORR_DIST_RST;
  out_item_t                   windows_due[$];

  int mismatches    = 0;
  int items_sent    = 0;
  int search_cursor = 0;
  bit idle_on       = 1'b1;
  int stall_left    = 0;

  monotonic_table_bracket_search_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("tb_monotonic_table_bracket_search_top NOT OK");
    $finish;
  end

  task automatic report(input string msg);
    if (mismatches < 100) $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Hunt / bisection on the shadow table; queues the expected window
  function automatic void predict_search(input in_item_t item);
    cmd_e                        cmd;
    out_item_t                   res;
    logic signed [KEY_WIDTH-1:0] key;
    int                          n, m, lo, hi, mid, stride, saved, gap, start, top;
    bit                          rising;
    cmd = cmd_e'(item.command);
    key = item.key_value;
    n   = cfg_size;
    m   = cfg_window;
    if (cmd == CMD_WRITE) begin
      key_store[item.entry_index] = key;
      return;
    end
    if (cmd == CMD_UNUSED) return;
    res = '0;
    if (n < 2 || m < 2 || m > n || n > TABLE_DEPTH) begin
      res.size_error = 1'b1;
      windows_due.push_back(res);
      return;
    end
    rising = key_store[n-1] >= key_store[0];
    saved  = last_bracket;
    lo     = 0;
    hi     = n - 1;
    // hunt phase only from a bracket that still lies in the table
    if (cmd == CMD_HUNT && saved <= n - 1) begin
      lo     = saved;
      stride = 1;
      if ((key >= key_store[lo]) == rising) begin
        forever begin
          hi = lo + stride;
          if (hi >= n - 1) begin
            hi = n - 1;
            break;
          end
          if ((key < key_store[hi]) == rising) break;
          lo     = hi;
          stride += stride;
        end
      end else begin
        hi = lo;
        forever begin
          lo = lo - stride;
          if (lo <= 0) begin
            lo = 0;
            break;
          end
          if ((key >= key_store[lo]) == rising) break;
          hi     = lo;
          stride += stride;
        end
      end
    end
    while (hi - lo > 1) begin
      mid = (hi + lo) / 2;
      if ((key >= key_store[mid]) == rising) lo = mid;
      else hi = mid;
    end
    gap            = (lo > saved) ? lo - saved : saved - lo;
    res.correlated = (gap <= int'(cfg_reach));
    last_bracket   = lo[IDX_W-1:0];
    // window centered on the bracket, clamped into the table
    start = lo - ((m - 2) >> 1);
    top   = n - m;
    if (start > top) start = top;
    if (start < 0) start = 0;
    res.window_start = start[IDX_W-1:0];
    windows_due.push_back(res);
  endfunction

  task automatic check_window(input out_item_t got);
    out_item_t want;
    if (windows_due.size() == 0) begin
      report($sformatf("result with nothing pending: start %0d corr %0b err %0b",
                       got.window_start, got.correlated, got.size_error));
      return;
    end
    want = windows_due.pop_front();
    if (got.window_start !== want.window_start)
      report($sformatf("window_start %0d, want %0d", got.window_start, want.window_start));
    if (got.correlated !== want.correlated)
      report($sformatf("correlated %0b, want %0b", got.correlated, want.correlated));
    if (got.size_error !== want.size_error)
      report($sformatf("size_error %0b, want %0b", got.size_error, want.size_error));
  endtask

  // Result side: check each transfer, then pick the next stall value
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_window(out_item_o);
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        stall_left = $urandom_range(0, 7);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // One input transfer, with an occasional gap ahead of it
  task automatic send_item(input cmd_e cmd, input logic signed [KEY_WIDTH-1:0] key,
                           input logic [IDX_W-1:0] index);
    in_item_t item;
    item.command     = cmd;
    item.key_value   = key;
    item.entry_index = index;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_search(item);
    items_sent++;
  endtask

  // Wait for every pending result, then let trailing writes retire
  task automatic drain();
    in_valid_i <= 1'b0;
    while (windows_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input int value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[CFG_W-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_TABLE_SIZE:    cfg_size   = value[CFG_W-1:0];
      CFG_WINDOW_POINTS: cfg_window = value[CFG_W-1:0];
      CFG_CORR_DIST:     cfg_reach  = value[CFG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int n, input int m, input int d);
    drain();
    cfg_write(CFG_TABLE_SIZE, n);
    cfg_write(CFG_WINDOW_POINTS, m);
    cfg_write(CFG_CORR_DIST, d);
    cfg_valid_i <= 1'b0;
  endtask

  // Write entries 0..n-1 in the given shape
  task automatic fill_table(input int n, input table_shape_e shape, input bit full_span);
    int     a, b, i, slot;
    longint lo, hi, span, v, prev;
    a = $urandom;
    b = $urandom;
    if (full_span) begin
      a = KEY_MIN;
      b = KEY_MAX;
    end
    lo   = (a < b) ? a : b;
    hi   = (a < b) ? b : a;
    if (shape == SHAPE_FLAT) hi = lo;
    span = hi - lo;
    prev = lo;
    for (i = 0; i < n; i++) begin
      v = lo + span * i / (n - 1);
      // repeated keys keep the order but make flat runs
      if (i > 0 && !full_span && $urandom_range(0, 7) == 0) v = prev;
      prev = v;
      slot = (shape == SHAPE_FALLING) ? n - 1 - i : i;
      if (shape == SHAPE_SCRAMBLED) begin
        a = $urandom;
        v = a;
      end
      send_item(CMD_WRITE, v[KEY_WIDTH-1:0], slot[IDX_W-1:0]);
    end
  endtask

  // Search key: mostly near table keys, walking close to the last one
  function automatic logic signed [KEY_WIDTH-1:0] pick_key(input int n);
    int     r, j, off, raw;
    longint v;
    r   = $urandom_range(0, 99);
    raw = $urandom;
    if (n < 2 || n > TABLE_DEPTH || r < 15) return raw;
    if (r < 22) return (r[0]) ? KEY_MIN : KEY_MAX;
    if ($urandom_range(0, 1) == 1) j = search_cursor + int'($urandom_range(0, 16)) - 8;
    else j = $urandom_range(0, n - 1);
    if (j < 0) j = 0;
    if (j > n - 1) j = n - 1;
    search_cursor = j;
    v = key_store[j];
    if (r >= 60) begin
      off = $urandom_range(0, 6);
      v   = v + off - 3;
    end
    if (v < longint'(KEY_MIN)) v = KEY_MIN;
    if (v > longint'(KEY_MAX)) v = KEY_MAX;
    return v[KEY_WIDTH-1:0];
  endfunction

  task automatic run_searches(input int count, input int n);
    int r, k;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 68) send_item(CMD_HUNT, pick_key(n), $urandom_range(0, TABLE_DEPTH - 1));
      else if (r < 92) send_item(CMD_LOCATE, pick_key(n), $urandom_range(0, TABLE_DEPTH - 1));
      else if (r < 96) send_item(CMD_UNUSED, $urandom, $urandom_range(0, TABLE_DEPTH - 1));
      else send_item(CMD_WRITE, $urandom, $urandom_range(0, TABLE_DEPTH - 1));
    end
  endtask

  // Reset sizes: two-entry table with the key extremes
  task automatic test_reset_config();
    send_item(CMD_WRITE, KEY_MIN, 0);
    send_item(CMD_WRITE, KEY_MAX, 1);
    send_item(CMD_LOCATE, 0, 0);
    send_item(CMD_HUNT, KEY_MAX, 0);
    send_item(CMD_UNUSED, 32'h1234_5678, 10'h3ff);
  endtask

  // Invalid table or window sizes give only the error flag
  task automatic test_size_errors();
    configure(1, 2, 1);
    send_item(CMD_LOCATE, 5, 0);
    configure(0, 0, 0);
    send_item(CMD_HUNT, -5, 0);
    configure(8, 1, 1);
    send_item(CMD_LOCATE, 0, 0);
    configure(8, 9, 1);
    send_item(CMD_HUNT, 0, 0);
    configure(2047, 2, 1);
    send_item(CMD_LOCATE, 0, 0);
  endtask

  // Small ascending table with duplicates: edges, hunt up and hunt down
  task automatic test_directed_search();
    logic signed [KEY_WIDTH-1:0] keys [12];
    int i;
    keys = '{KEY_MIN, -1000, -1000, -5, 0, 7, 100, 100, 5000, 1000000, 32'sh4000_0000,
             KEY_MAX};
    for (i = 0; i < 12; i++) send_item(CMD_WRITE, keys[i], i[IDX_W-1:0]);
    configure(12, 4, 0);
    send_item(CMD_LOCATE, KEY_MIN, 0);
    send_item(CMD_HUNT, KEY_MAX, 0);
    send_item(CMD_HUNT, -1000, 0);
    send_item(CMD_HUNT, 100, 0);
    send_item(CMD_LOCATE, 5, 0);
  endtask

  // Whole table in use; every entry written, largest valid table and window sizes
  task automatic test_full_table();
    configure(TABLE_DEPTH, TABLE_DEPTH, TABLE_DEPTH);
    fill_table(TABLE_DEPTH, SHAPE_RISING, 1'b1);
    run_searches(6, TABLE_DEPTH);
    configure(TABLE_DEPTH, 2, 0);
    run_searches(20, TABLE_DEPTH);
    configure(TABLE_DEPTH, 9, 1023);
    run_searches(10, TABLE_DEPTH);
  endtask

  // Random phases: new sizes, often a fresh table, then a run of searches
  task automatic test_random_phases();
    int           base, n, m, d, r;
    table_shape_e shape;
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      idle_on = (items_sent - base < RANDOM_ITEMS * 4 / 5) && ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 3) n = $urandom_range(0, 1);
      else if (r < 6) n = $urandom_range(TABLE_DEPTH + 1, 2047);
      else if (r < 70) n = $urandom_range(2, 32);
      else if (r < 95) n = $urandom_range(33, 128);
      else n = $urandom_range(129, TABLE_DEPTH);
      r = $urandom_range(0, 99);
      if (r < 5) m = $urandom_range(0, 1);
      else if (r < 10 && n < 2047) m = $urandom_range(n + 1, 2047);
      else if (r < 20) m = n;
      else if (n < 2) m = $urandom_range(2, 8);
      else m = $urandom_range(2, (n > TABLE_DEPTH) ? TABLE_DEPTH : n);
      r = $urandom_range(0, 99);
      if (r < 15) d = 0;
      else if (r < 25) d = n;
      else if (r < 30) d = 2047;
      else d = $urandom_range(0, (n > TABLE_DEPTH) ? TABLE_DEPTH : n);
      configure(n, m, d);
      if (n >= 2 && n <= TABLE_DEPTH && $urandom_range(0, 4) != 0) begin
        r = $urandom_range(0, 99);
        if (r < 40) shape = SHAPE_RISING;
        else if (r < 80) shape = SHAPE_FALLING;
        else if (r < 85) shape = SHAPE_FLAT;
        else shape = SHAPE_SCRAMBLED;
        fill_table(n, shape, $urandom_range(0, 7) == 0);
      end
      run_searches($urandom_range(8, 40), n);
    end
    idle_on = 1'b0;
  endtask

  initial begin
    int waited;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_config();
    test_size_errors();
    test_directed_search();
    test_full_table();
    test_random_phases();
    in_valid_i <= 1'b0;
    waited = 0;
    while (windows_due.size() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    if (windows_due.size() != 0)
      report($sformatf("%0d results never arrived", windows_due.size()));
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_monotonic_table_bracket_search_top OK");
    end else begin
      $display("tb_monotonic_table_bracket_search_top NOT OK");
    end
    $finish;
  end

endmodule
